// ----- src/jfd_pkg.sv -----
`timescale 1ns / 1ps

package jfd_pkg;

	// fixed field widths of the channels and registers
	localparam int unsigned HANDLE_W    = 16;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned LEVEL_W     = 7;
	localparam int unsigned REJ_TOTAL_W = 32;
	localparam int unsigned REJ_ROW_W   = 16;
	localparam int unsigned ACC_SINCE_W = 32;
	localparam int unsigned CFG_DATA_W  = 32;

	// reset values of the configuration registers
	localparam logic [LEVEL_W-1:0] HOLD_BACK_RST     = 7'd0;
	localparam logic [LEVEL_W-1:0] DROP_THRESHOLD_RST = 7'd32;
	localparam logic [LEVEL_W-1:0] MAX_FILL_RST      = 7'd64;
	localparam logic [TIME_W-1:0]  DROP_INTERVAL_RST = 32'd1000000;

	typedef enum logic [0:0] {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_HOLD_BACK      = 2'd0,
		REG_DROP_THRESHOLD = 2'd1,
		REG_MAX_FILL       = 2'd2,
		REG_DROP_INTERVAL  = 2'd3
	} cfg_reg_t;

endpackage

// ----- src/jfd_cmd_if.sv -----
`timescale 1ns / 1ps

interface jfd_cmd_if
	import jfd_pkg::*;
();
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [HANDLE_W-1:0] frame_handle;
	logic [TIME_W-1:0]   time_now_us;

	modport source (output valid, output opcode, output frame_handle, output time_now_us,
		input ready);
	modport sink (input valid, input opcode, input frame_handle, input time_now_us,
		output ready);
endinterface

// ----- src/jfd_res_if.sv -----
`timescale 1ns / 1ps

interface jfd_res_if
	import jfd_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [HANDLE_W-1:0]    out_handle;
	logic                   oldest_dropped;
	logic [LEVEL_W-1:0]     fill_level;
	logic [REJ_TOTAL_W-1:0] rejected_total;
	logic [REJ_ROW_W-1:0]   rejects_in_row;
	logic [ACC_SINCE_W-1:0] accepted_since_reject;

	modport source (output valid, output accepted, output out_handle, output oldest_dropped,
		output fill_level, output rejected_total, output rejects_in_row,
		output accepted_since_reject, input ready);
	modport sink (input valid, input accepted, input out_handle, input oldest_dropped,
		input fill_level, input rejected_total, input rejects_in_row,
		input accepted_since_reject, output ready);
endinterface

// ----- src/jitter_fifo_with_timed_drop_top.sv -----
`timescale 1ns / 1ps
// pipeline: a result passes from its command transfer through the decision stage and then
// the output register, and a stalled output register holds the command side back
// throughput: one command per cycle while results are taken; pointers, fill and counters
// update at the transfer and the handle memory is read and written in that same cycle
// reset: arst_n clears pointers, fill, counters, drop time and the pipeline valids and
// loads the register defaults; the handle memory is not cleared (no clearing pass)
module jitter_fifo_with_timed_drop_top
	import jfd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 64,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	jfd_cmd_if.sink               cmd,
	jfd_res_if.source             res
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CW = (FW > LEVEL_W) ? FW : LEVEL_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

	// configuration registers
	logic [LEVEL_W-1:0] hold_back_q;
	logic [LEVEL_W-1:0] drop_thr_q;
	logic [LEVEL_W-1:0] max_fill_q;
	logic [TIME_W-1:0]  drop_int_q;

	// queue state
	logic [HANDLE_BITS-1:0] handle_store_q [QUEUE_DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [FW-1:0]          fill_q;
	logic [TIME_W-1:0]      last_drop_q;
	logic [REJ_TOTAL_W-1:0] rej_total_q;
	logic [REJ_ROW_W-1:0]   rej_row_q;
	logic [ACC_SINCE_W-1:0] acc_since_q;

	// stage 1: decision taken, memory read in flight
	logic                   valid_s1;
	logic                   acc_s1;
	logic                   drop_s1;
	logic                   pop_s1;
	logic [LEVEL_W-1:0]     fill_s1;
	logic [REJ_TOTAL_W-1:0] rej_total_s1;
	logic [REJ_ROW_W-1:0]   rej_row_s1;
	logic [ACC_SINCE_W-1:0] acc_since_s1;
	logic [HANDLE_BITS-1:0] rd_data_s1;

	// output register
	logic                   res_valid_q;
	logic                   res_acc_q;
	logic [HANDLE_W-1:0]    res_handle_q;
	logic                   res_drop_q;
	logic [LEVEL_W-1:0]     res_fill_q;
	logic [REJ_TOTAL_W-1:0] res_rej_total_q;
	logic [REJ_ROW_W-1:0]   res_rej_row_q;
	logic [ACC_SINCE_W-1:0] res_acc_since_q;

	// decision logic
	logic                   out_free;
	logic                   cmd_fire;
	logic                   is_enq;
	logic                   above_hold;
	logic                   timed;
	logic                   pop;
	logic                   reject;
	logic                   push;
	logic [CW-1:0]          limit_c;
	logic [FW-1:0]          fill_mid;
	logic [FW-1:0]          fill_nxt;
	logic [TIME_W-1:0]      elapsed;
	logic [PW-1:0]          wr_ptr_nxt;
	logic [PW-1:0]          rd_ptr_nxt;
	logic [HANDLE_BITS-1:0] handle_w;
	logic [REJ_TOTAL_W-1:0] rej_total_nxt;
	logic [REJ_ROW_W-1:0]   rej_row_nxt;
	logic [ACC_SINCE_W-1:0] acc_since_nxt;

	// handshake: stage 1 drains whenever the output register is free
	assign out_free  = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// timed drop, reject and pointer decisions
	always_comb begin
		is_enq     = (cmd.opcode == OP_ENQUEUE);
		above_hold = CW'(fill_q) > CW'(hold_back_q);
		limit_c    = (CW'(max_fill_q) > DEPTH_C) ? DEPTH_C : CW'(max_fill_q);
		elapsed    = cmd.time_now_us - last_drop_q;
		timed      = is_enq && (CW'(fill_q) > CW'(drop_thr_q)) && (elapsed >= drop_int_q);
		pop        = above_hold && (!is_enq || timed);
		fill_mid   = fill_q - FW'(pop);
		reject     = is_enq && (CW'(fill_mid) >= limit_c);
		push       = is_enq && !reject;
		fill_nxt   = fill_mid + FW'(push);
		wr_ptr_nxt = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
		rd_ptr_nxt = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
		handle_w   = HANDLE_BITS'(cmd.frame_handle);

		rej_total_nxt = rej_total_q;
		rej_row_nxt   = rej_row_q;
		acc_since_nxt = acc_since_q;
		if (reject) begin
			if (rej_total_q != '1) rej_total_nxt = rej_total_q + 1'b1;
			if (rej_row_q != '1) rej_row_nxt = rej_row_q + 1'b1;
			acc_since_nxt = '0;
		end else if (push) begin
			rej_row_nxt = '0;
			if (acc_since_q != '1) acc_since_nxt = acc_since_q + 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_back_q <= HOLD_BACK_RST;
			drop_thr_q  <= DROP_THRESHOLD_RST;
			max_fill_q  <= MAX_FILL_RST;
			drop_int_q  <= DROP_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HOLD_BACK:      hold_back_q <= cfg_data[LEVEL_W-1:0];
				REG_DROP_THRESHOLD: drop_thr_q  <= cfg_data[LEVEL_W-1:0];
				REG_MAX_FILL:       max_fill_q  <= cfg_data[LEVEL_W-1:0];
				REG_DROP_INTERVAL:  drop_int_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// queue pointers, fill, drop time and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			last_drop_q <= '0;
			rej_total_q <= '0;
			rej_row_q   <= '0;
			acc_since_q <= '0;
		end else if (cmd_fire) begin
			if (push) wr_ptr_q <= wr_ptr_nxt;
			if (pop) rd_ptr_q <= rd_ptr_nxt;
			if (timed) last_drop_q <= cmd.time_now_us;
			fill_q      <= fill_nxt;
			rej_total_q <= rej_total_nxt;
			rej_row_q   <= rej_row_nxt;
			acc_since_q <= acc_since_nxt;
		end
	end

	// handle memory: read of the oldest entry returns data from before this cycle's write
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			if (push) handle_store_q[wr_ptr_q] <= handle_w;
			rd_data_s1 <= handle_store_q[rd_ptr_q];
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			acc_s1       <= push || (!is_enq && pop);
			drop_s1      <= is_enq && pop;
			pop_s1       <= pop;
			fill_s1      <= LEVEL_W'(fill_nxt);
			rej_total_s1 <= rej_total_nxt;
			rej_row_s1   <= rej_row_nxt;
			acc_since_s1 <= acc_since_nxt;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_acc_q       <= acc_s1;
			res_handle_q    <= pop_s1 ? HANDLE_W'(rd_data_s1) : '0;
			res_drop_q      <= drop_s1;
			res_fill_q      <= fill_s1;
			res_rej_total_q <= rej_total_s1;
			res_rej_row_q   <= rej_row_s1;
			res_acc_since_q <= acc_since_s1;
		end
	end

	assign res.valid                 = res_valid_q;
	assign res.accepted              = res_acc_q;
	assign res.out_handle            = res_handle_q;
	assign res.oldest_dropped        = res_drop_q;
	assign res.fill_level            = res_fill_q;
	assign res.rejected_total        = res_rej_total_q;
	assign res.rejects_in_row        = res_rej_row_q;
	assign res.accepted_since_reject = res_acc_since_q;

	// an empty queue has its pointers together
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	// fill only moves on a command transfer
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_fire |=> $stable(fill_q))
		else $error("fill changed without a command transfer");

	// a decided item reaches the output register when it is free
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> res_valid_q)
		else $error("stage 1 item lost on its way to the output");

	// a timed drop restamps the drop time
	a_restamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && pop && is_enq) |=> (last_drop_q == $past(cmd.time_now_us)))
		else $error("timed drop did not restamp the drop time");

endmodule

// ----- tb/tb_jitter_fifo_with_timed_drop_top.sv -----
`timescale 1ns / 1ps

module tb_jitter_fifo_with_timed_drop_top;
	import jfd_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic                   accepted;
		logic [HANDLE_W-1:0]    out_handle;
		logic                   oldest_dropped;
		logic [LEVEL_W-1:0]     fill_level;
		logic [REJ_TOTAL_W-1:0] rejected_total;
		logic [REJ_ROW_W-1:0]   rejects_in_row;
		logic [ACC_SINCE_W-1:0] accepted_since_reject;
	} fifo_outcome_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_GOLD,
		ROW_PREDICT
	} row_kind_t;

	typedef enum logic [1:0] {
		PRESS_NONE,
		PRESS_HOLD_RESULTS,
		PRESS_PAUSE_SENDER
	} pressure_t;

	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] value;
		opcode_t               op;
		logic [HANDLE_W-1:0]   handle;
		logic [TIME_W-1:0]     stamp;
		fifo_outcome_t         gold;
	} plan_row_t;

	// directed rows, outcome typed in where it follows at a glance
	localparam int PLAN_LEN = 30;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// empty dequeue, then both handle and time extremes through the ring
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'h0000, 32'h0000_0000,
			'{1'b0, 16'h0000, 1'b0, 7'd0, 32'd0, 16'd0, 32'd0}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'hFFFF, 32'h0000_0000,
			'{1'b1, 16'h0000, 1'b0, 7'd1, 32'd0, 16'd0, 32'd1}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h0000, 32'hFFFF_FFFF,
			'{1'b1, 16'h0000, 1'b0, 7'd2, 32'd0, 16'd0, 32'd2}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'h0000, 32'h0000_0000,
			'{1'b1, 16'hFFFF, 1'b0, 7'd1, 32'd0, 16'd0, 32'd2}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'hFFFF, 32'h0000_0000,
			'{1'b1, 16'h0000, 1'b0, 7'd0, 32'd0, 16'd0, 32'd2}},
		// zero max fill rejects every frame
		'{ROW_CFG, REG_MAX_FILL, 32'd0, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'hA5A5, 32'h0000_0001,
			'{1'b0, 16'h0000, 1'b0, 7'd0, 32'd1, 16'd1, 32'd0}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h5A5A, 32'h0000_0002,
			'{1'b0, 16'h0000, 1'b0, 7'd0, 32'd2, 16'd2, 32'd0}},
		// max fill beyond the depth
		'{ROW_CFG, REG_MAX_FILL, 32'd127, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h5A5A, 32'h0000_0003,
			'{1'b1, 16'h0000, 1'b0, 7'd1, 32'd2, 16'd0, 32'd1}},
		// zero threshold and zero interval drop the oldest on every enqueue to a non-empty queue
		'{ROW_CFG, REG_DROP_THRESHOLD, 32'd0, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_CFG, REG_DROP_INTERVAL, 32'd0, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h1234, 32'h0000_0005,
			'{1'b1, 16'h5A5A, 1'b1, 7'd1, 32'd2, 16'd0, 32'd2}},
		// hold-back blocks the drop but the stamp still moves; blocked dequeue
		'{ROW_CFG, REG_HOLD_BACK, 32'd1, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h00FF, 32'h0000_0064,
			'{1'b1, 16'h0000, 1'b0, 7'd2, 32'd2, 16'd0, 32'd3}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'h0000, 32'h0000_0000,
			'{1'b1, 16'h1234, 1'b0, 7'd1, 32'd2, 16'd0, 32'd3}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'h0000, 32'h0000_0000,
			'{1'b0, 16'h0000, 1'b0, 7'd1, 32'd2, 16'd0, 32'd3}},
		// widest interval reached only by a wrapped time difference
		'{ROW_CFG, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_CFG, REG_DROP_INTERVAL, 32'hFFFF_FFFF, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'hC3C3, 32'h0000_0063,
			'{1'b1, 16'h00FF, 1'b1, 7'd1, 32'd2, 16'd0, 32'd4}},
		'{ROW_GOLD, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h3C3C, 32'h0000_0064,
			'{1'b1, 16'h0000, 1'b0, 7'd2, 32'd2, 16'd0, 32'd5}},
		// default interval with a low threshold
		'{ROW_CFG, REG_DROP_INTERVAL, 32'd1000000, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_CFG, REG_DROP_THRESHOLD, 32'd2, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_PREDICT, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h8001, 32'h8000_0000, '0},
		'{ROW_PREDICT, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h7FFE, 32'h8000_0001, '0},
		'{ROW_PREDICT, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'h0000, 32'h0000_0000, '0},
		'{ROW_PREDICT, REG_HOLD_BACK, 32'd0, OP_DEQUEUE, 16'hFFFF, 32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, REG_HOLD_BACK, 32'd0, OP_ENQUEUE, 16'h0001, 32'h7FFF_FFFF, '0},
		'{ROW_CFG, REG_MAX_FILL, 32'd64, OP_ENQUEUE, 16'h0000, 32'h0, '0},
		'{ROW_CFG, REG_DROP_THRESHOLD, 32'd32, OP_ENQUEUE, 16'h0000, 32'h0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jfd_cmd_if cmd_if ();
	jfd_res_if res_if ();

	jitter_fifo_with_timed_drop_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_if),
		.res       (res_if)
	);

	always #5 clk = ~clk;

	// shadow registers and queue state of the predictor
	logic [LEVEL_W-1:0]     cfg_hold   = HOLD_BACK_RST;
	logic [LEVEL_W-1:0]     cfg_thresh = DROP_THRESHOLD_RST;
	logic [LEVEL_W-1:0]     cfg_max    = MAX_FILL_RST;
	logic [TIME_W-1:0]      cfg_gap    = DROP_INTERVAL_RST;
	logic [HANDLE_W-1:0]    fifo_ring [DEPTH];
	int unsigned            ring_wr      = 0;
	int unsigned            ring_rd      = 0;
	int unsigned            ring_fill    = 0;
	logic [TIME_W-1:0]      last_drop_us = '0;
	logic [REJ_TOTAL_W-1:0] reject_total = '0;
	logic [REJ_ROW_W-1:0]   reject_run   = '0;
	logic [ACC_SINCE_W-1:0] accept_run   = '0;

	fifo_outcome_t due_outcomes [$];
	int unsigned   fail_count    = 0;
	int unsigned   hold_requests = 0;
	bit            steady_flow   = 1'b0;

	function automatic logic [HANDLE_W-1:0] pop_oldest_frame();
		logic [HANDLE_W-1:0] h;
		h         = fifo_ring[ring_rd];
		ring_rd   = (ring_rd + 1) % DEPTH;
		ring_fill = ring_fill - 1;
		return h;
	endfunction

	function automatic fifo_outcome_t predict_fifo_op(opcode_t op, logic [HANDLE_W-1:0] handle,
			logic [TIME_W-1:0] now_us);
		fifo_outcome_t     o;
		int unsigned       limit;
		logic [TIME_W-1:0] since_drop;
		o          = '0;
		since_drop = now_us - last_drop_us;
		if (op == OP_ENQUEUE) begin
			limit = (cfg_max > DEPTH) ? DEPTH : cfg_max;
			// timed drop, restamped even when hold-back keeps the frame
			if (ring_fill > cfg_thresh && since_drop >= cfg_gap) begin
				if (ring_fill > cfg_hold) begin
					o.out_handle     = pop_oldest_frame();
					o.oldest_dropped = 1'b1;
				end
				last_drop_us = now_us;
			end
			// admit or reject the new frame
			if (ring_fill >= limit) begin
				if (reject_run != '1)
					reject_run++;
				if (reject_total != '1)
					reject_total++;
				accept_run = '0;
			end else begin
				reject_run = '0;
				if (accept_run != '1)
					accept_run++;
				fifo_ring[ring_wr] = handle;
				ring_wr            = (ring_wr + 1) % DEPTH;
				ring_fill          = ring_fill + 1;
				o.accepted         = 1'b1;
			end
		end else if (ring_fill > cfg_hold) begin
			o.out_handle = pop_oldest_frame();
			o.accepted   = 1'b1;
		end
		o.fill_level            = LEVEL_W'(ring_fill);
		o.rejected_total        = reject_total;
		o.rejects_in_row        = reject_run;
		o.accepted_since_reject = accept_run;
		return o;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
		end
	endtask

	task automatic check_outcome();
		fifo_outcome_t want;
		if (due_outcomes.size() == 0) begin
			fail_count++;
			$error("result transfer with no outcome outstanding");
			return;
		end
		want = due_outcomes.pop_front();
		compare_field("accepted", want.accepted, res_if.accepted);
		compare_field("out_handle", want.out_handle, res_if.out_handle);
		compare_field("oldest_dropped", want.oldest_dropped, res_if.oldest_dropped);
		compare_field("fill_level", want.fill_level, res_if.fill_level);
		compare_field("rejected_total", want.rejected_total, res_if.rejected_total);
		compare_field("rejects_in_row", want.rejects_in_row, res_if.rejects_in_row);
		compare_field("accepted_since_reject", want.accepted_since_reject,
			res_if.accepted_since_reject);
	endtask

	// one register write, mirrored into the predictor
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_HOLD_BACK:      cfg_hold   = data[LEVEL_W-1:0];
			REG_DROP_THRESHOLD: cfg_thresh = data[LEVEL_W-1:0];
			REG_MAX_FILL:       cfg_max    = data[LEVEL_W-1:0];
			REG_DROP_INTERVAL:  cfg_gap    = data[TIME_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		while (due_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one command and log its outcome at the transfer
	task automatic push_cmd(opcode_t op, logic [HANDLE_W-1:0] handle, logic [TIME_W-1:0] stamp,
			bit use_gold, fifo_outcome_t gold);
		fifo_outcome_t predicted;
		while (!steady_flow && $urandom_range(99) < 37) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid        <= 1'b1;
		cmd_if.opcode       <= op;
		cmd_if.frame_handle <= handle;
		cmd_if.time_now_us  <= stamp;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		predicted = predict_fifo_op(op, handle, stamp);
		due_outcomes.push_back(use_gold ? gold : predicted);
	endtask

	task automatic run_phase(logic [LEVEL_W-1:0] hold, logic [LEVEL_W-1:0] thresh,
			logic [LEVEL_W-1:0] max_fill, logic [TIME_W-1:0] gap, int unsigned count,
			int unsigned enq_pct, int unsigned max_step, bit steady, bit swing,
			pressure_t pressure);
		logic [TIME_W-1:0] clock_us;
		logic [TIME_W-1:0] stamp;
		int unsigned       pct;
		opcode_t           op;
		drain_results();
		write_reg(REG_HOLD_BACK, CFG_DATA_W'(hold));
		write_reg(REG_DROP_THRESHOLD, CFG_DATA_W'(thresh));
		write_reg(REG_MAX_FILL, CFG_DATA_W'(max_fill));
		write_reg(REG_DROP_INTERVAL, gap);
		steady_flow = steady;
		clock_us    = $urandom();
		for (int unsigned i = 0; i < count; i++) begin
			// alternate fill and drain bias so the level sweeps its range
			pct = (swing && (i / 40) % 2 == 1) ? 100 - enq_pct : enq_pct;
			op  = ($urandom_range(99) < pct) ? OP_ENQUEUE : OP_DEQUEUE;
			// mostly advancing time, now and then an arbitrary stamp
			if ($urandom_range(99) < 5) begin
				stamp = $urandom();
			end else begin
				clock_us = clock_us + $urandom_range(max_step, 0);
				stamp    = clock_us;
			end
			if (i == count / 3) begin
				if (pressure == PRESS_HOLD_RESULTS) begin
					hold_requests++;
				end else if (pressure == PRESS_PAUSE_SENDER) begin
					cmd_if.valid <= 1'b0;
					do @(posedge clk); while (due_outcomes.size() != 0);
				end
			end
			push_cmd(op, HANDLE_W'($urandom_range(16'hFFFF, 0)), stamp, 1'b0, '0);
		end
		steady_flow = 1'b0;
	endtask

	// result side: random ready, long hold-offs on request
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned holds_seen;
		hold_left    = 0;
		holds_seen   = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
				check_outcome();
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= steady_flow || ($urandom_range(99) >= 37);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("jitter_fifo_with_timed_drop_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= REG_HOLD_BACK;
		cfg_data            <= '0;
		cmd_if.valid        <= 1'b0;
		cmd_if.opcode       <= OP_ENQUEUE;
		cmd_if.frame_handle <= '0;
		cmd_if.time_now_us  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_CFG) begin
				drain_results();
				write_reg(PLAN[r].reg_sel, PLAN[r].value);
			end else begin
				push_cmd(PLAN[r].op, PLAN[r].handle, PLAN[r].stamp, PLAN[r].kind == ROW_GOLD,
					PLAN[r].gold);
			end
		end

		// random phases over a spread of settings
		run_phase(7'd0, 7'd32, 7'd64, 32'd1000, 180, 70, 300, 1'b0, 1'b1,
			PRESS_HOLD_RESULTS);
		run_phase(7'd0, 7'd0, 7'd64, 32'd0, 170, 65, 10, 1'b1, 1'b1, PRESS_NONE);
		run_phase(7'd5, 7'd10, 7'd20, 32'd50, 170, 70, 40, 1'b0, 1'b1, PRESS_PAUSE_SENDER);
		run_phase(7'd64, 7'd64, 7'd64, 32'd1000000, 170, 75, 50000, 1'b0, 1'b1, PRESS_NONE);
		run_phase(7'd127, 7'd127, 7'd127, 32'hFFFF_FFFF, 170, 75, 100000, 1'b0, 1'b1,
			PRESS_NONE);
		run_phase(7'd0, 7'd63, 7'd64, 32'd200, 180, 80, 150, 1'b0, 1'b1, PRESS_NONE);
		run_phase(LEVEL_W'($urandom_range(20, 0)), LEVEL_W'($urandom_range(64, 0)),
			LEVEL_W'($urandom_range(64, 1)), TIME_W'($urandom_range(500, 0)), 180, 70, 100,
			1'b0, 1'b1, PRESS_NONE);
		run_phase(7'd3, 7'd40, 7'd100, 32'd10, 180, 60, 20, 1'b0, 1'b1, PRESS_NONE);

		// back-to-back reject run with a zero max fill
		run_phase(7'd0, 7'd0, 7'd0, 32'd0, 40, 100, 10, 1'b1, 1'b0, PRESS_NONE);

		drain_results();
		if (fail_count == 0)
			$display("jitter_fifo_with_timed_drop_top: match");
		else
			$display("jitter_fifo_with_timed_drop_top: mismatch");
		$finish;
	end

endmodule
